// ----- rtl/core/crsm_pkg.sv -----
// crsm_pkg: shared widths, action codes and payload structs of the contiguous ring
// space manager, plus the buffer size clamp helpers.
// Standalone package; used by crsm_exec and contiguous_ring_space_manager.
package crsm_pkg;

    // offset width, length and total widths, and the widths derived from them
    localparam int OFFSET_BITS = 16;
    localparam int SIZE_W      = OFFSET_BITS + 1;
    localparam int LEN_W       = 17;
    localparam int TOTAL_W     = 32;
    localparam int ARITH_W     = ((SIZE_W > LEN_W) ? SIZE_W : LEN_W) + 2;

    localparam logic [LEN_W-1:0] RESET_SIZE = LEN_W'(8192);
    localparam logic [LEN_W-1:0] USED_MAX   = {LEN_W{1'b1}};

    typedef logic [OFFSET_BITS-1:0] t_ofs;
    typedef logic [LEN_W-1:0]       t_len;

    typedef enum logic [2:0] {
        ACT_RESERVE       = 3'd0,
        ACT_RESERVE_CARRY = 3'd1,
        ACT_RETRACT       = 3'd2,
        ACT_COMMIT_USED   = 3'd3,
        ACT_RELEASE       = 3'd4,
        ACT_FETCH_READ    = 3'd5,
        ACT_REINIT        = 3'd6,
        ACT_UNUSED        = 3'd7
    } t_action;

    // ring bookkeeping state
    typedef struct packed {
        t_ofs                 write_offset;
        t_ofs                 read_offset;
        t_ofs                 wrap_mark;
        t_len                 used_bytes;
        logic [TOTAL_W-1:0]   total_bytes;
    } t_state;

    // one input item
    typedef struct packed {
        t_action action;
        t_len    length;
        t_len    next_length;
        t_len    carry_length;
        t_len    read_request;
    } t_item;

    // one result item
    typedef struct packed {
        logic               ok;
        t_ofs               offset;
        t_len               granted;
        logic               copy_valid;
        t_ofs               copy_source;
        t_len               copy_length;
        t_len               used_count;
        logic [TOTAL_W-1:0] total_count;
    } t_result;

    // clamp the programmed size to [1, 2^OFFSET_BITS]
    function automatic logic [SIZE_W-1:0] eff_size(input t_len value);
        logic [ARITH_W-1:0] wide;
        logic [ARITH_W-1:0] cap;
        wide = ARITH_W'(value);
        cap  = ARITH_W'(1) << OFFSET_BITS;
        if (wide == '0) begin
            wide = ARITH_W'(1);
        end else if (wide > cap) begin
            wide = cap;
        end
        return SIZE_W'(wide);
    endfunction

    // last usable offset for a clamped size
    function automatic t_ofs end_of(input logic [SIZE_W-1:0] size);
        return t_ofs'(size - SIZE_W'(1));
    endfunction

endpackage

// ----- rtl/core/crsm_exec.sv -----
// crsm_exec: combinational action unit, one item against the current ring state,
// giving the next state and the result item.
// Depends on crsm_pkg.
module crsm_exec
    import crsm_pkg::*;
(
    input  t_state             i_state,
    input  t_item              i_item,
    input  logic [SIZE_W-1:0]  i_size,
    input  t_ofs               i_end,
    output t_state             o_state,
    output t_result            o_result
);

    logic [ARITH_W-1:0] w_wo;
    logic [ARITH_W-1:0] w_len;
    logic [ARITH_W-1:0] w_nxt;
    logic [ARITH_W-1:0] w_used;
    logic [ARITH_W-1:0] w_size;
    logic [ARITH_W-1:0] w_end;
    logic [ARITH_W-1:0] w_used_len;
    logic [ARITH_W-1:0] w_wo_len;
    t_len               used_sub;
    t_ofs               fetch_ro;
    t_ofs               fetch_wrap;
    t_len               want;
    logic [ARITH_W-1:0] avail;
    t_len               grant;

    // widened operands and shared sums
    assign w_wo       = ARITH_W'(i_state.write_offset);
    assign w_len      = ARITH_W'(i_item.length);
    assign w_nxt      = ARITH_W'(i_item.next_length);
    assign w_used     = ARITH_W'(i_state.used_bytes);
    assign w_size     = ARITH_W'(i_size);
    assign w_end      = ARITH_W'(i_end);
    assign w_used_len = w_used + w_len;
    assign w_wo_len   = w_wo + w_len;

    // saturating used decrement
    assign used_sub = (i_state.used_bytes > i_item.length) ?
                      (i_state.used_bytes - i_item.length) : '0;

    // read side: reset to start once the wrap mark is reached
    assign fetch_ro   = (i_state.wrap_mark == i_state.read_offset) ? '0 : i_state.read_offset;
    assign fetch_wrap = (i_state.wrap_mark == i_state.read_offset) ? i_end : i_state.wrap_mark;
    assign want       = (i_state.used_bytes > i_item.read_request) ?
                        i_item.read_request : i_state.used_bytes;
    assign avail      = (fetch_wrap > fetch_ro) ? ARITH_W'(fetch_wrap - fetch_ro) : '0;
    assign grant      = (avail >= ARITH_W'(want)) ? want : LEN_W'(avail);

    // action decode
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.ok = 1'b1;
        case (i_item.action)
            ACT_RESERVE: begin
                if (w_used_len > w_size) begin
                    o_result.ok = 1'b0;
                end else begin
                    if (w_end >= w_wo_len) begin
                        o_result.offset      = i_state.write_offset;
                        o_state.write_offset = t_ofs'(w_wo_len);
                    end else begin
                        o_state.wrap_mark    = i_state.write_offset;
                        o_state.write_offset = t_ofs'(w_len);
                    end
                    o_state.used_bytes  = LEN_W'(w_used_len);
                    o_state.total_bytes = i_state.total_bytes + TOTAL_W'(i_item.length);
                end
            end
            ACT_RESERVE_CARRY: begin
                if (w_used_len + w_nxt > w_size) begin
                    o_result.ok = 1'b0;
                end else begin
                    if (w_end > w_wo_len + w_nxt) begin
                        o_state.write_offset = t_ofs'(w_wo_len);
                    end else begin
                        o_state.wrap_mark      = i_state.write_offset;
                        o_result.copy_valid    = 1'b1;
                        o_result.copy_source   = t_ofs'(w_wo_len
                                                 - ARITH_W'(i_item.carry_length));
                        o_result.copy_length   = i_item.carry_length;
                        o_state.write_offset   = t_ofs'(ARITH_W'(i_item.carry_length));
                    end
                    o_result.offset     = o_state.write_offset;
                    o_state.used_bytes  = LEN_W'(w_used_len);
                    o_state.total_bytes = i_state.total_bytes + TOTAL_W'(i_item.length);
                end
            end
            ACT_RETRACT: begin
                o_state.used_bytes   = used_sub;
                o_state.write_offset = t_ofs'(w_wo - w_len);
            end
            ACT_COMMIT_USED: begin
                o_state.used_bytes  = (w_used_len > ARITH_W'(USED_MAX)) ?
                                      USED_MAX : LEN_W'(w_used_len);
                o_state.total_bytes = i_state.total_bytes + TOTAL_W'(i_item.length);
            end
            ACT_RELEASE: begin
                o_state.used_bytes = used_sub;
            end
            ACT_FETCH_READ: begin
                o_state.read_offset = fetch_ro;
                o_state.wrap_mark   = fetch_wrap;
                if (i_state.used_bytes == '0) begin
                    o_result.ok = 1'b0;
                end else begin
                    o_result.granted    = grant;
                    o_result.offset     = fetch_ro;
                    o_state.read_offset = t_ofs'(ARITH_W'(fetch_ro) + ARITH_W'(grant));
                end
            end
            ACT_REINIT: begin
                o_state.write_offset = '0;
                o_state.read_offset  = '0;
                o_state.wrap_mark    = i_end;
                o_state.used_bytes   = '0;
                o_state.total_bytes  = '0;
            end
            default: begin
                o_result.ok = 1'b0;
            end
        endcase
        o_result.used_count  = o_state.used_bytes;
        o_result.total_count = o_state.total_bytes;
    end

endmodule

// ----- rtl/core/contiguous_ring_space_manager.sv -----
// contiguous_ring_space_manager: offset bookkeeping for a contiguous-region ring buffer.
// From input transfer to result valid the item passes the input register, then the result register.
// Throughput: one item per cycle while the output is ready; the single action unit
// reads the state the previous item left, so items follow back to back without a bubble.
// Reset (synchronous, active low): empty ring, buffer size 8192, no items held.
// Depends on crsm_pkg and crsm_exec.
module contiguous_ring_space_manager
    import crsm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  t_len               i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_action,
    input  t_len               i_length,
    input  t_len               i_next_length,
    input  t_len               i_carry_length,
    input  t_len               i_read_request,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_ok,
    output t_ofs               o_offset,
    output t_len               o_granted,
    output logic               o_copy_valid,
    output t_ofs               o_copy_source,
    output t_len               o_copy_length,
    output t_len               o_used_count,
    output logic [TOTAL_W-1:0] o_total_count
);

    logic               r_in_valid;
    t_item              r_item;
    logic               r_out_valid;
    t_result            r_res;
    t_state             r_state;
    logic [SIZE_W-1:0]  r_size;
    t_ofs               r_end;

    t_state             n_state;
    t_result            n_res;
    logic [SIZE_W-1:0]  cfg_size;
    logic               advance;
    logic               in_xfer;

    // handshake: item moves to the result register when that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign cfg_size   = eff_size(i_cfg_data);

    // action unit
    crsm_exec u_exec (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_size   (r_size),
        .i_end    (r_end),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.action       <= t_action'(i_action);
            r_item.length       <= i_length;
            r_item.next_length  <= i_next_length;
            r_item.carry_length <= i_carry_length;
            r_item.read_request <= i_read_request;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    // ring state and size; a config write reinitializes the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size                <= eff_size(RESET_SIZE);
            r_end                 <= end_of(eff_size(RESET_SIZE));
            r_state.write_offset  <= '0;
            r_state.read_offset   <= '0;
            r_state.wrap_mark     <= end_of(eff_size(RESET_SIZE));
            r_state.used_bytes    <= '0;
            r_state.total_bytes   <= '0;
        end else if (i_cfg_we) begin
            r_size                <= cfg_size;
            r_end                 <= end_of(cfg_size);
            r_state.write_offset  <= '0;
            r_state.read_offset   <= '0;
            r_state.wrap_mark     <= end_of(cfg_size);
            r_state.used_bytes    <= '0;
            r_state.total_bytes   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output ports
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_res.ok;
    assign o_offset      = r_res.offset;
    assign o_granted     = r_res.granted;
    assign o_copy_valid  = r_res.copy_valid;
    assign o_copy_source = r_res.copy_source;
    assign o_copy_length = r_res.copy_length;
    assign o_used_count  = r_res.used_count;
    assign o_total_count = r_res.total_count;

    // a refused reserve leaves the ring untouched
    a_refused_reserve_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !i_cfg_we && !n_res.ok
         && (r_item.action == ACT_RESERVE || r_item.action == ACT_RESERVE_CARRY))
        |=> $stable(r_state))
        else $error("refused reserve changed ring state");

    // a config write empties the ring
    a_cfg_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state.write_offset == '0 && r_state.read_offset == '0
                      && r_state.used_bytes == '0 && r_state.total_bytes == '0
                      && r_state.wrap_mark == r_end))
        else $error("config write did not reinitialize the ring");

    // a successful fetch moves the read offset past the granted chunk
    a_fetch_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !i_cfg_we && n_res.ok && r_item.action == ACT_FETCH_READ)
        |=> (r_state.read_offset
             == t_ofs'($past(n_res.offset) + t_ofs'($past(n_res.granted)))))
        else $error("fetch did not advance the read offset by the grant");

endmodule
